/* rtl/lsce_pkg.sv */
// Shared types, codes and helpers for the LED strip color effect block.
// No dependencies; every rtl file imports it.
package lsce_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned PHASE_W = 12;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned DEF_MAX_LEDS = 1024;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);
  localparam logic [PHASE_W-1:0] FADE_LIMIT = PHASE_W'(255);

  // animation modes
  localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FADE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WIPE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MID   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd4;

  // commands
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] led_index;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
  } pixel_t;

  // settings seen by the datapath; len is already clamped to 1..max
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } cfg_t;

  // floor(c * p / 255) for p <= 255: reciprocal by shift and add
  function automatic logic [COLOR_W-1:0] fade_scale(input logic [COLOR_W-1:0] c,
                                                    input logic [COLOR_W-1:0] p);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = c * p;
    sum  = {1'b0, prod} + 17'(prod >> 8) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

/* rtl/lsce_cfg.sv */
// Configuration registers of the LED strip color effect block.
// Depends on lsce_pkg; clamps the strip length to 1..MAX_LEDS, at most 2047.
module lsce_cfg import lsce_pkg::*; #(
  parameter int unsigned MAX_LEDS = DEF_MAX_LEDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned LEN_CAP = (MAX_LEDS < LEN_MAX) ? MAX_LEDS : LEN_MAX;

  logic [MODE_W-1:0]  mode;
  logic [LEN_W-1:0]   strip_length;
  logic [COLOR_W-1:0] color_red;
  logic [COLOR_W-1:0] color_green;
  logic [COLOR_W-1:0] color_blue;
  logic [LEN_W-1:0]   len_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_OFF;
      strip_length <= LEN_RESET;
      color_red    <= '0;
      color_green  <= '0;
      color_blue   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:   mode         <= cfg_data[MODE_W-1:0];
        REG_LENGTH: strip_length <= cfg_data[LEN_W-1:0];
        REG_RED:    color_red    <= cfg_data[COLOR_W-1:0];
        REG_GREEN:  color_green  <= cfg_data[COLOR_W-1:0];
        REG_BLUE:   color_blue   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_clamped = strip_length;
    if (strip_length == '0) len_clamped = LEN_W'(1);
    if (strip_length > LEN_W'(LEN_CAP)) len_clamped = LEN_W'(LEN_CAP);
  end

  assign cfg = '{mode: mode, len: len_clamped, red: color_red,
                 green: color_green, blue: color_blue};

endmodule

/* rtl/lsce_phase.sv */
// Ping-pong phase counter with mode limit and clamped display phase.
// Depends on lsce_pkg.
module lsce_phase import lsce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               tick,
  output logic [PHASE_W-1:0] phase,
  output logic [PHASE_W-1:0] disp_phase
);

  logic               going_down;
  logic               going_down_next;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] limit;
  logic               dir;

  always_comb begin
    case (cfg.mode)
      MODE_FADE: limit = FADE_LIMIT;
      MODE_WIPE: limit = {cfg.len, 1'b0};
      MODE_MID:  limit = PHASE_W'(cfg.len);
      default:   limit = '0;
    endcase
    disp_phase = (phase < limit) ? phase : limit;
  end

  always_comb begin
    dir = going_down;
    if (disp_phase >= limit) dir = 1'b1;
    if (disp_phase == '0) dir = 1'b0;
    phase_next = dir ? disp_phase - PHASE_W'(1) : disp_phase + PHASE_W'(1);
    going_down_next = (phase_next == limit || phase_next == '0) ? !dir : dir;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      going_down <= 1'b0;
    end else if (tick && limit != '0) begin
      phase      <= phase_next;
      going_down <= going_down_next;
    end
  end

endmodule

/* rtl/lsce_pixel.sv */
// Color of one LED at the displayed phase: lit test per mode, fade scaling.
// Depends on lsce_pkg.
module lsce_pixel import lsce_pkg::*; (
  input  cfg_t               cfg,
  input  logic [PHASE_W-1:0] disp_phase,
  input  logic [IDX_W-1:0]   led_index,
  output pixel_t             pixel
);

  localparam int unsigned W = PHASE_W + 1;

  logic [W-1:0] i;
  logic [W-1:0] n;
  logic [W-1:0] p;
  logic [W-1:0] m;
  logic [W-1:0] s;
  logic         lit;
  logic [COLOR_W-1:0] r;
  logic [COLOR_W-1:0] g;
  logic [COLOR_W-1:0] b;

  always_comb begin
    i = W'(led_index);
    n = W'(cfg.len);
    p = W'(disp_phase);
    m = n >> 1;
    s = p - m;
    lit = 1'b0;
    if (i < n) begin
      case (cfg.mode)
        MODE_SOLID, MODE_FADE: lit = 1'b1;
        MODE_WIPE: lit = (p > n) ? (i >= p - n) : (i < p);
        // past the midpoint the lit run shrinks to [s, n - s)
        MODE_MID:  lit = (p > m) ? (i >= s && i < n - s) : (i < p || i >= n - p);
        default:   lit = 1'b0;
      endcase
    end
  end

  always_comb begin
    r = '0;
    g = '0;
    b = '0;
    if (lit) begin
      if (cfg.mode == MODE_FADE) begin
        r = fade_scale(cfg.red,   disp_phase[COLOR_W-1:0]);
        g = fade_scale(cfg.green, disp_phase[COLOR_W-1:0]);
        b = fade_scale(cfg.blue,  disp_phase[COLOR_W-1:0]);
      end else begin
        r = cfg.red;
        g = cfg.green;
        b = cfg.blue;
      end
    end
  end

  assign pixel = '{pixel_index: led_index, pixel_red: r, pixel_green: g, pixel_blue: b};

endmodule

/* rtl/led_strip_color_effect.sv */
// LED strip color effect: solid-color animations driven by a ping-pong phase.
// A query word passes the input register and then the result register before it
// shows on pixel; a result word not yet taken holds it in the input register.
// Throughput: one word per cycle unless a query waits for the result register; ticks
// and queries may follow back to back, a query sees every tick accepted before it.
// Reset (synchronous, rst high): mode off, strip length 64, black color, phase 0
// counting up, both pipeline registers empty.
module led_strip_color_effect import lsce_pkg::*; #(
  parameter int unsigned MAX_LEDS = DEF_MAX_LEDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  pixel_valid,
  input  logic                  pixel_ready,
  output pixel_t                pixel
);

  cfg_t               cfg;
  logic               s1_valid;
  item_t              s1_word;
  logic               s1_tick;
  logic               s1_query;
  logic               s1_advance;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] disp_phase;
  pixel_t             pixel_next;

  lsce_cfg #(.MAX_LEDS(MAX_LEDS)) u_cfg (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  assign s1_tick  = s1_valid && s1_word.command == CMD_TICK;
  assign s1_query = s1_valid && s1_word.command == CMD_QUERY;
  // a tick never waits; a query waits only for a free result register
  assign s1_advance = !s1_query || !pixel_valid || pixel_ready;
  assign item_ready = s1_advance;

  lsce_phase u_phase (
    .clk(clk), .rst(rst), .cfg(cfg), .tick(s1_tick),
    .phase(phase), .disp_phase(disp_phase)
  );

  lsce_pixel u_pixel (
    .cfg(cfg), .disp_phase(disp_phase), .led_index(s1_word.led_index),
    .pixel(pixel_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && item_valid) begin
      s1_word <= item;
    end
  end

  // hold a waiting pixel word until it is taken, even while ticks pass by
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (s1_query && s1_advance) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_query && s1_advance) begin
      pixel <= pixel_next;
    end
  end

  a_tick_no_stall: assert property (@(posedge clk) disable iff (rst)
    s1_tick |-> s1_advance) else $error("tick held in input register");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_tick |=> $stable(phase)) else $error("phase moved without a tick");

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(s1_query)) else $error("result without a query");

  a_off_black: assert property (@(posedge clk) disable iff (rst)
    s1_query && s1_advance && cfg.mode == MODE_OFF |=>
      pixel.pixel_red == '0 && pixel.pixel_green == '0 && pixel.pixel_blue == '0)
    else $error("lit pixel in off mode");

endmodule

/* tb/led_strip_color_effect_checker.sv */
// Checker for the LED strip color effect block: tracks the register writes and
// the phase counter, predicts every pixel word and compares it with the block.
// Depends on lsce_pkg for the word types, mode codes and register indexes.
`timescale 1ns / 100ps

module led_strip_color_effect_checker import lsce_pkg::*; #(
  parameter int unsigned MAX_LEDS = DEF_MAX_LEDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  item_t                 item,
  input  logic                  pixel_valid,
  input  logic                  pixel_ready,
  input  pixel_t                pixel,
  output int                    pending,
  output int                    errors
);

  logic [MODE_W-1:0]  mode_q;
  logic [LEN_W-1:0]   len_q;
  logic [COLOR_W-1:0] red_q;
  logic [COLOR_W-1:0] green_q;
  logic [COLOR_W-1:0] blue_q;
  logic [PHASE_W-1:0] phase_q;
  logic               down_q;
  pixel_t             want_pixels[$];

  function automatic int strip_len();
    int n;
    n = int'(len_q);
    if (n < 1) n = 1;
    if (n > int'(MAX_LEDS)) n = int'(MAX_LEDS);
    return n;
  endfunction

  function automatic int phase_limit(input int n);
    case (mode_q)
      MODE_FADE: return int'(FADE_LIMIT);
      MODE_WIPE: return 2 * n;
      MODE_MID:  return n;
      default:   return 0;
    endcase
  endfunction

  // clamp to the mode limit, bounce at either end, step once
  task automatic step_phase();
    int n;
    int lim;
    int p;
    n = strip_len();
    lim = phase_limit(n);
    if (lim == 0) return;
    p = (int'(phase_q) < lim) ? int'(phase_q) : lim;
    if (p >= lim) down_q = 1'b1;
    if (p == 0) down_q = 1'b0;
    p = down_q ? p - 1 : p + 1;
    if (p == lim || p == 0) down_q = !down_q;
    phase_q = PHASE_W'(p);
  endtask

  function automatic pixel_t shade_led(input logic [IDX_W-1:0] idx);
    int     n;
    int     lim;
    int     p;
    int     i;
    int     m;
    int     s;
    int     run;
    bit     on;
    pixel_t px;
    n = strip_len();
    lim = phase_limit(n);
    p = (int'(phase_q) < lim) ? int'(phase_q) : lim;
    i = int'(idx);
    case (mode_q)
      MODE_SOLID, MODE_FADE: on = 1'b1;
      MODE_WIPE: on = (p > n) ? (i >= p - n) : (i < p);
      MODE_MID: begin
        m = n / 2;
        if (p > m) begin
          // shrinking back out through the middle; a negative run lights nothing
          s = p - m;
          run = n - 2 * s;
          on = run > 0 && i >= s && i < s + run;
        end else begin
          on = i < p || i >= n - p;
        end
      end
      default: on = 1'b0;
    endcase
    if (i >= n) on = 1'b0;
    px.pixel_index = idx;
    px.pixel_red   = '0;
    px.pixel_green = '0;
    px.pixel_blue  = '0;
    if (on) begin
      if (mode_q == MODE_FADE) begin
        px.pixel_red   = COLOR_W'(int'(red_q) * p / int'(FADE_LIMIT));
        px.pixel_green = COLOR_W'(int'(green_q) * p / int'(FADE_LIMIT));
        px.pixel_blue  = COLOR_W'(int'(blue_q) * p / int'(FADE_LIMIT));
      end else begin
        px.pixel_red   = red_q;
        px.pixel_green = green_q;
        px.pixel_blue  = blue_q;
      end
    end
    return px;
  endfunction

  task automatic take_pixel(input pixel_t got);
    pixel_t want;
    if (want_pixels.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected pixel word: index %0d rgb %0d/%0d/%0d",
                 got.pixel_index, got.pixel_red, got.pixel_green, got.pixel_blue);
      return;
    end
    want = want_pixels.pop_front();
    if (got.pixel_index !== want.pixel_index || got.pixel_red !== want.pixel_red ||
        got.pixel_green !== want.pixel_green || got.pixel_blue !== want.pixel_blue) begin
      errors++;
      if (errors <= 10)
        $display("pixel mismatch: expected index %0d rgb %0d/%0d/%0d, got index %0d rgb %0d/%0d/%0d",
                 want.pixel_index, want.pixel_red, want.pixel_green, want.pixel_blue,
                 got.pixel_index, got.pixel_red, got.pixel_green, got.pixel_blue);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_q  = MODE_OFF;
      len_q   = LEN_RESET;
      red_q   = '0;
      green_q = '0;
      blue_q  = '0;
      phase_q = '0;
      down_q  = 1'b0;
      want_pixels.delete();
    end else begin
      // a pixel word leaving now never belongs to a word accepted on this edge
      if (pixel_valid && pixel_ready) take_pixel(pixel);
      if (item_valid && item_ready) begin
        if (item.command == CMD_TICK) step_phase();
        else want_pixels.push_back(shade_led(item.led_index));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_MODE:   mode_q  = cfg_data[MODE_W-1:0];
          REG_LENGTH: len_q   = cfg_data[LEN_W-1:0];
          REG_RED:    red_q   = cfg_data[COLOR_W-1:0];
          REG_GREEN:  green_q = cfg_data[COLOR_W-1:0];
          REG_BLUE:   blue_q  = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
    pending = want_pixels.size();
  end

endmodule

/* tb/tb_led_strip_color_effect.sv */
// Top of the LED strip color effect testbench: clock, reset, register writes,
// tick and query words with random gaps and stalls, and the verdict.
// Depends on lsce_pkg, the block and led_strip_color_effect_checker.
`timescale 1ns / 100ps

module tb_led_strip_color_effect;
  import lsce_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  // codes the block treats as off
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_t                 item = '0;
  logic                  pixel_valid;
  logic                  pixel_ready = 1'b0;
  pixel_t                pixel;

  int pending;
  int errors;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int strip_n = 64;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  led_strip_color_effect dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

  led_strip_color_effect_checker pixel_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .pending     (pending),
    .errors      (errors)
  );

  always @(negedge clk) begin
    pixel_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // drop valid and wait until every pixel word is out and the pipeline is quiet
  task automatic settle();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  task automatic program_all(input logic [MODE_W-1:0] md, input int len,
                             input int red, input int green, input int blue);
    settle();
    write_reg(REG_MODE, int'(md));
    write_reg(REG_LENGTH, len);
    write_reg(REG_RED, red);
    write_reg(REG_GREEN, green);
    write_reg(REG_BLUE, blue);
    cfg_write <= 1'b0;
    strip_n = (len < 1) ? 1 : (len > int'(DEF_MAX_LEDS)) ? int'(DEF_MAX_LEDS) : len;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic cmd, input int idx);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= item_t'{command: cmd, led_index: IDX_W'(idx)};
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] md, input int len,
                           input int red, input int green, input int blue,
                           input int count, input int tick_pct,
                           input int sidle, input int rstall, input int hold);
    int top_idx;
    program_all(md, len, red, green, blue);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (hold > 0) begin
      // hold off the receiver so the block fills and stalls its input
      fork
        begin
          @(posedge clk);
          hold_off = 1'b1;
          repeat (hold) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
    end
    top_idx = (strip_n < 1023) ? strip_n : 1023;
    repeat (count) begin
      if ($urandom_range(99) < tick_pct) send_word(CMD_TICK, $urandom_range(1023));
      else if ($urandom_range(99) < 25) send_word(CMD_QUERY, $urandom_range(1023));
      else send_word(CMD_QUERY, $urandom_range(top_idx));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // settings straight out of reset: off, 64 LEDs; ticks are ignored
    send_word(CMD_QUERY, 0);
    send_word(CMD_QUERY, 1023);
    send_word(CMD_TICK, 0);
    send_word(CMD_QUERY, 63);
    send_word(CMD_QUERY, 64);

    program_all(MODE_SOLID, 1024, 255, 0, 85);
    send_word(CMD_QUERY, 1023);
    send_word(CMD_QUERY, 0);
    send_word(CMD_TICK, 1023);
    send_word(CMD_QUERY, 512);

    // zero length acts as one LED
    program_all(MODE_FADE, 0, 255, 255, 255);
    send_word(CMD_TICK, 0);
    send_word(CMD_QUERY, 0);
    send_word(CMD_QUERY, 1);
    send_word(CMD_TICK, 0);
    send_word(CMD_QUERY, 0);

    // oversized length with an unused mode code
    program_all(MODE_RSVD7, 2047, 255, 255, 255);
    send_word(CMD_TICK, 0);
    send_word(CMD_QUERY, 5);

    // odd strip: phase reaches the limit and the middle run goes negative
    program_all(MODE_MID, 3, 128, 64, 1);
    send_word(CMD_TICK, 0);
    send_word(CMD_QUERY, 1);
    send_word(CMD_QUERY, 0);
    send_word(CMD_QUERY, 2);

    run_phase(MODE_FADE, 16, 255, $urandom_range(255), 0, 450, 75, 0, 0, 0);
    run_phase(MODE_WIPE, 5, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              120, 40, 61, 0, 0);
    run_phase(MODE_MID, 7, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              120, 40, 0, 61, 0);
    run_phase(MODE_MID, 8, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              120, 40, 7, 7, 0);
    run_phase(MODE_WIPE, 1, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              80, 50, 0, 0, 0);
    run_phase(MODE_MID, 1, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              80, 50, 61, 0, 0);
    run_phase(MODE_MID, 0, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              60, 50, 0, 61, 0);
    run_phase(MODE_WIPE, 1024, 255, 255, 255, 150, 30, 7, 7, 0);
    run_phase(MODE_SOLID, 200, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              120, 10, 0, 0, 60);
    run_phase(MODE_RSVD5, 33, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              50, 30, 61, 0, 0);
    run_phase(MODE_RSVD6, 12, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              40, 40, 0, 61, 0);
    run_phase(MODE_RSVD7, 1500, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              40, 40, 7, 7, 0);
    run_phase(MODE_FADE, 2047, 0, 0, 0, 60, 50, 0, 0, 0);
    run_phase(MODE_OFF, 64, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              60, 30, 61, 0, 0);
    run_phase(MODE_WIPE, 13, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              120, 45, 0, 61, 0);
    run_phase(MODE_MID, 64, $urandom_range(255), $urandom_range(255), $urandom_range(255),
              150, 50, 7, 7, 0);

    settle();
    repeat (6) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lsce_pkg.sv
rtl/lsce_cfg.sv
rtl/lsce_phase.sv
rtl/lsce_pixel.sv
rtl/led_strip_color_effect.sv
tb/led_strip_color_effect_checker.sv
tb/tb_led_strip_color_effect.sv
